// ===== design/pecm_pkg.sv =====
// ----------------------------------------------------------------------------
// pecm_pkg: shared types, constants and microcode for the charge meter
// Holds the control word layout, the step program and the scaling constants.
// ----------------------------------------------------------------------------
`default_nettype none

package pecm_pkg;

    // Field widths
    localparam int VOLT_W  = 16;
    localparam int CURR_W  = 16;
    localparam int IVL_W   = 14;
    localparam int POWER_W = 23;
    localparam int ACC_W   = 32;
    localparam int SEC_W   = 16;
    localparam int STEP_W  = 10;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 2;
    localparam int PAGE_W  = 2;
    localparam int UNIT_W  = 3;

    // Shared multiplier: power (23 bits) by a 16-bit operand
    localparam int MUL_A_W = POWER_W;
    localparam int MUL_B_W = 16;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // Constant divider: 40-bit dividend, 20-bit divisor, 4 quotient bits a cycle
    localparam int DVD_W       = 40;
    localparam int DIV_W       = 20;
    localparam int DIV_BPC     = 4;
    localparam int DIV_CYCLES  = DVD_W / DIV_BPC;
    localparam int DCNT_W      = $clog2(DIV_CYCLES + 1);

    // Scaling constants
    localparam logic [DIV_W-1:0] DIV_MS   = DIV_W'(1000);
    localparam logic [DIV_W-1:0] DIV_HOUR = DIV_W'(3600);
    localparam logic [DIV_W-1:0] DIV_BIG  = DIV_W'(1000000);
    localparam logic [POWER_W-1:0] SMALL_POWER_MAX = POWER_W'(65535);
    localparam logic [ACC_W-1:0]   SMALL_TOTAL_MAX = ACC_W'(65535000);

    // Configuration reset values
    localparam logic [CFG_W-1:0]  MIN_RESET      = CFG_W'(5000);
    localparam logic [CFG_W-1:0]  MAX_RESET      = CFG_W'(5000);
    localparam logic [STEP_W-1:0] STEP_RESET     = STEP_W'(20);
    localparam logic [CFG_W-1:0]  LIMIT_RESET    = CFG_W'(6000);
    localparam logic [VOLT_W-1:0] SETPOINT_RESET = VOLT_W'(5000);

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_MIN_MV   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_MAX_MV   = 2'd1;
    localparam logic [CIDX_W-1:0] REG_STEP_MV  = 2'd2;
    localparam logic [CIDX_W-1:0] REG_LIMIT_MA = 2'd3;

    // Display pages and units
    localparam logic [PAGE_W-1:0] PAGE_POWER  = 2'd0;
    localparam logic [PAGE_W-1:0] PAGE_ENERGY = 2'd1;
    localparam logic [PAGE_W-1:0] PAGE_CHARGE = 2'd2;
    localparam logic [PAGE_W-1:0] PAGE_TIME   = 2'd3;

    localparam logic [UNIT_W-1:0] UNIT_MW  = 3'd0;
    localparam logic [UNIT_W-1:0] UNIT_W_  = 3'd1;
    localparam logic [UNIT_W-1:0] UNIT_MWH = 3'd2;
    localparam logic [UNIT_W-1:0] UNIT_WH  = 3'd3;
    localparam logic [UNIT_W-1:0] UNIT_MAH = 3'd4;
    localparam logic [UNIT_W-1:0] UNIT_AH  = 3'd5;
    localparam logic [UNIT_W-1:0] UNIT_HMS = 3'd6;

    // Control word fields
    typedef enum logic [1:0] {MUL_NONE, MUL_VC, MUL_IC, MUL_IP} mul_sel_t;
    typedef enum logic [1:0] {DS_PROD, DS_DUR, DS_PAGE} div_src_t;
    typedef enum logic [1:0] {DC_MS, DC_HOUR, DC_PAGE} div_const_t;
    typedef enum logic [2:0] {
        WB_NONE, WB_POWER, WB_CHARGE, WB_ENERGY, WB_SECONDS, WB_OUT
    } wb_sel_t;
    typedef enum logic [1:0] {J_NEXT, J_WAIT_IN, J_DIV, J_OUT} jmp_t;

    localparam int UPC_W = 5;

    typedef struct packed {
        mul_sel_t         mul;
        logic             misc_upd;
        logic             div_load;
        div_src_t         div_src;
        div_const_t       div_const;
        wb_sel_t          wb;
        jmp_t             jmp;
        logic [UPC_W-1:0] target;
    } uword_t;

    // Step addresses
    localparam logic [UPC_W-1:0] UPC_WAIT    = 5'd0;
    localparam logic [UPC_W-1:0] UPC_MUL_VC  = 5'd1;
    localparam logic [UPC_W-1:0] UPC_LD_PWR  = 5'd2;
    localparam logic [UPC_W-1:0] UPC_DV_PWR  = 5'd3;
    localparam logic [UPC_W-1:0] UPC_WB_PWR  = 5'd4;
    localparam logic [UPC_W-1:0] UPC_LD_CHG  = 5'd5;
    localparam logic [UPC_W-1:0] UPC_DV_CHG  = 5'd6;
    localparam logic [UPC_W-1:0] UPC_WB_CHG  = 5'd7;
    localparam logic [UPC_W-1:0] UPC_LD_NRG  = 5'd8;
    localparam logic [UPC_W-1:0] UPC_DV_NRG  = 5'd9;
    localparam logic [UPC_W-1:0] UPC_WB_NRG  = 5'd10;
    localparam logic [UPC_W-1:0] UPC_LD_SEC  = 5'd11;
    localparam logic [UPC_W-1:0] UPC_DV_SEC  = 5'd12;
    localparam logic [UPC_W-1:0] UPC_WB_SEC  = 5'd13;
    localparam logic [UPC_W-1:0] UPC_LD_PAGE = 5'd14;
    localparam logic [UPC_W-1:0] UPC_DV_PAGE = 5'd15;
    localparam logic [UPC_W-1:0] UPC_OUT     = 5'd16;

    // Build one control word
    function automatic uword_t uw(input mul_sel_t m, input logic misc, input logic ld,
                                  input div_src_t src, input div_const_t dc,
                                  input wb_sel_t wb, input jmp_t j,
                                  input logic [UPC_W-1:0] tgt);
        uword_t w;
        w.mul       = m;
        w.misc_upd  = misc;
        w.div_load  = ld;
        w.div_src   = src;
        w.div_const = dc;
        w.wb        = wb;
        w.jmp       = j;
        w.target    = tgt;
        return w;
    endfunction

    // Microcode program
    function automatic uword_t ucode(input logic [UPC_W-1:0] pc);
        uword_t w;
        unique case (pc)
            UPC_WAIT:    w = uw(MUL_NONE, 1'b0, 1'b0, DS_PROD, DC_MS,   WB_NONE,
                                J_WAIT_IN, UPC_WAIT);
            UPC_MUL_VC:  w = uw(MUL_VC,   1'b1, 1'b0, DS_PROD, DC_MS,   WB_NONE,
                                J_NEXT, UPC_WAIT);
            UPC_LD_PWR:  w = uw(MUL_NONE, 1'b0, 1'b1, DS_PROD, DC_MS,   WB_NONE,
                                J_NEXT, UPC_WAIT);
            UPC_DV_PWR:  w = uw(MUL_NONE, 1'b0, 1'b0, DS_PROD, DC_MS,   WB_NONE,
                                J_DIV, UPC_DV_PWR);
            UPC_WB_PWR:  w = uw(MUL_IC,   1'b0, 1'b0, DS_PROD, DC_MS,   WB_POWER,
                                J_NEXT, UPC_WAIT);
            UPC_LD_CHG:  w = uw(MUL_NONE, 1'b0, 1'b1, DS_PROD, DC_HOUR, WB_NONE,
                                J_NEXT, UPC_WAIT);
            UPC_DV_CHG:  w = uw(MUL_NONE, 1'b0, 1'b0, DS_PROD, DC_MS,   WB_NONE,
                                J_DIV, UPC_DV_CHG);
            UPC_WB_CHG:  w = uw(MUL_IP,   1'b0, 1'b0, DS_PROD, DC_MS,   WB_CHARGE,
                                J_NEXT, UPC_WAIT);
            UPC_LD_NRG:  w = uw(MUL_NONE, 1'b0, 1'b1, DS_PROD, DC_HOUR, WB_NONE,
                                J_NEXT, UPC_WAIT);
            UPC_DV_NRG:  w = uw(MUL_NONE, 1'b0, 1'b0, DS_PROD, DC_MS,   WB_NONE,
                                J_DIV, UPC_DV_NRG);
            UPC_WB_NRG:  w = uw(MUL_NONE, 1'b0, 1'b0, DS_PROD, DC_MS,   WB_ENERGY,
                                J_NEXT, UPC_WAIT);
            UPC_LD_SEC:  w = uw(MUL_NONE, 1'b0, 1'b1, DS_DUR,  DC_MS,   WB_NONE,
                                J_NEXT, UPC_WAIT);
            UPC_DV_SEC:  w = uw(MUL_NONE, 1'b0, 1'b0, DS_PROD, DC_MS,   WB_NONE,
                                J_DIV, UPC_DV_SEC);
            UPC_WB_SEC:  w = uw(MUL_NONE, 1'b0, 1'b0, DS_PROD, DC_MS,   WB_SECONDS,
                                J_NEXT, UPC_WAIT);
            UPC_LD_PAGE: w = uw(MUL_NONE, 1'b0, 1'b1, DS_PAGE, DC_PAGE, WB_NONE,
                                J_NEXT, UPC_WAIT);
            UPC_DV_PAGE: w = uw(MUL_NONE, 1'b0, 1'b0, DS_PROD, DC_MS,   WB_NONE,
                                J_DIV, UPC_DV_PAGE);
            UPC_OUT:     w = uw(MUL_NONE, 1'b0, 1'b0, DS_PROD, DC_MS,   WB_OUT,
                                J_OUT, UPC_WAIT);
            default:     w = uw(MUL_NONE, 1'b0, 1'b0, DS_PROD, DC_MS,   WB_NONE,
                                J_OUT, UPC_WAIT);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== design/power_energy_charge_meter_unit.sv =====
// One item is taken at a time: a new item is accepted only at the wait step, after
// the previous item has left the output step. The shared constant divider retires
// 4 quotient bits a cycle and runs five 40-bit divisions per item.
// A finished item waits in the output register while the next one is taken in.
// Reset (aresetn low, synchronous): totals zero, setpoint 5000 mV, registers at
// their reset values, sequencer at its wait step, no result pending.
// ----------------------------------------------------------------------------
// power_energy_charge_meter_unit: power, energy and charge meter
// Microcoded sequencer over a shared 23x16 multiplier and a radix-2 divider
// by constants; accumulates energy, charge and duration and picks a page.
// ----------------------------------------------------------------------------
`default_nettype none

module power_energy_charge_meter_unit
    import pecm_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,

    input  wire logic                cfg_wr_en,
    input  wire logic [CIDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]    cfg_wdata,

    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire logic [VOLT_W-1:0]   s_voltage_mv,
    input  wire logic [CURR_W-1:0]   s_current_ma,
    input  wire logic [IVL_W-1:0]    s_interval_ms,
    input  wire logic                s_clear_pressed,
    input  wire logic                s_up_pressed,
    input  wire logic                s_down_pressed,

    output logic                     m_valid,
    input  wire logic                m_ready,
    output logic [POWER_W-1:0]       m_power_mw,
    output logic [ACC_W-1:0]         m_energy_uwh,
    output logic [ACC_W-1:0]         m_charge_uah,
    output logic [SEC_W-1:0]         m_elapsed_s,
    output logic [VOLT_W-1:0]        m_setpoint_mv,
    output logic [PAGE_W-1:0]        m_page,
    output logic [POWER_W-1:0]       m_page_value,
    output logic [UNIT_W-1:0]        m_page_unit,
    output logic [CURR_W-1:0]        m_qualified_current_ma
);

    // Configuration registers
    logic [CFG_W-1:0]  min_reg;
    logic [CFG_W-1:0]  max_reg;
    logic [STEP_W-1:0] step_reg;
    logic [CFG_W-1:0]  limit_reg;

    // Sequencer
    logic [UPC_W-1:0]  pc_reg;
    logic [UPC_W-1:0]  pc_next;
    uword_t            uw_cur;
    logic              in_fire;
    logic              out_fire;
    logic              m_valid_reg;

    // Latched item
    logic [VOLT_W-1:0] volt_reg;
    logic [CURR_W-1:0] curr_reg;
    logic [IVL_W-1:0]  ivl_reg;
    logic              clr_reg;
    logic              up_reg;
    logic              down_reg;

    // State and intermediate results
    logic [ACC_W-1:0]   dur_reg;
    logic [ACC_W-1:0]   energy_reg;
    logic [ACC_W-1:0]   charge_reg;
    logic [VOLT_W-1:0]  setpoint_reg;
    logic [VOLT_W-1:0]  setpoint_next;
    logic [POWER_W-1:0] power_reg;
    logic [SEC_W-1:0]   seconds_reg;

    // Multiplier
    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic [PROD_W-1:0]  prod_reg;

    // Divider
    logic [DVD_W-1:0]  qd_reg;
    logic [DVD_W-1:0]  qd_next;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  rem_next;
    logic [DIV_W-1:0]  divisor_reg;
    logic [DCNT_W-1:0] div_cnt_reg;
    logic [DIV_W:0]    div_r;
    logic [DVD_W-1:0]  div_q;
    logic [DVD_W-1:0]  dvd_sel;
    logic [DIV_W-1:0]  dvs_sel;

    // Page selection
    logic [PAGE_W-1:0]  page_w;
    logic               power_big;
    logic               energy_big;
    logic               charge_big;
    logic [POWER_W-1:0] pval_w;
    logic [UNIT_W-1:0]  punit_w;

    // Setpoint arithmetic
    logic [VOLT_W:0]   sp_up;
    logic [VOLT_W-1:0] sp_dn;
    logic [VOLT_W-1:0] step_ext;

    assign uw_cur   = ucode(pc_reg);
    assign s_ready  = (pc_reg == UPC_WAIT);
    assign in_fire  = s_valid && s_ready;
    assign out_fire = (uw_cur.jmp == J_OUT) && (!m_valid_reg || m_ready);
    assign m_valid  = m_valid_reg;

    // Step counter with conditional jumps
    always_comb begin
        pc_next = pc_reg + UPC_W'(1);
        unique case (uw_cur.jmp)
            J_NEXT:    pc_next = pc_reg + UPC_W'(1);
            J_WAIT_IN: if (!in_fire) pc_next = uw_cur.target;
            J_DIV:     if (div_cnt_reg != DCNT_W'(1)) pc_next = uw_cur.target;
            J_OUT: begin
                if (out_fire) pc_next = uw_cur.target;
                else          pc_next = pc_reg;
            end
            default:   pc_next = UPC_WAIT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg      <= UPC_WAIT;
            m_valid_reg <= 1'b0;
        end else begin
            pc_reg <= pc_next;
            if (out_fire)     m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
        end
    end

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg   <= MIN_RESET;
            max_reg   <= MAX_RESET;
            step_reg  <= STEP_RESET;
            limit_reg <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MIN_MV:   min_reg   <= cfg_wdata;
                REG_MAX_MV:   max_reg   <= cfg_wdata;
                REG_STEP_MV:  step_reg  <= cfg_wdata[STEP_W-1:0];
                REG_LIMIT_MA: limit_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    // Latch the item; drop currents above the limit
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            volt_reg <= s_voltage_mv;
            curr_reg <= (s_current_ma > limit_reg) ? '0 : s_current_ma;
            ivl_reg  <= s_interval_ms;
            clr_reg  <= s_clear_pressed;
            up_reg   <= s_up_pressed;
            down_reg <= s_down_pressed;
        end
    end

    // Setpoint step: up wins, clamp without wrap
    always_comb begin
        step_ext = {{(VOLT_W-STEP_W){1'b0}}, step_reg};
        sp_up    = {1'b0, setpoint_reg} + {1'b0, step_ext};
        sp_dn    = setpoint_reg - step_ext;
        setpoint_next = setpoint_reg;
        if (up_reg) begin
            if (sp_up > {1'b0, max_reg}) setpoint_next = max_reg;
            else                         setpoint_next = sp_up[VOLT_W-1:0];
        end else if (down_reg) begin
            if (setpoint_reg < step_ext || sp_dn < min_reg) setpoint_next = min_reg;
            else                                            setpoint_next = sp_dn;
        end
    end

    // Shared multiplier operands
    always_comb begin
        unique case (uw_cur.mul)
            MUL_VC: begin
                mul_a = MUL_A_W'(volt_reg);
                mul_b = curr_reg;
            end
            MUL_IC: begin
                mul_a = MUL_A_W'(ivl_reg);
                mul_b = curr_reg;
            end
            MUL_IP: begin
                mul_a = power_reg;
                mul_b = MUL_B_W'(ivl_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (uw_cur.mul != MUL_NONE) prod_reg <= mul_a * mul_b;
    end

    // Page and its scaling
    always_comb begin
        page_w     = seconds_reg[3:2];
        power_big  = power_reg > SMALL_POWER_MAX;
        energy_big = energy_reg > SMALL_TOTAL_MAX;
        charge_big = charge_reg > SMALL_TOTAL_MAX;
    end

    // Divider operand selection
    always_comb begin
        unique case (uw_cur.div_src)
            DS_PROD: dvd_sel = DVD_W'(prod_reg);
            DS_DUR:  dvd_sel = DVD_W'(dur_reg);
            default: begin
                unique case (page_w)
                    PAGE_POWER:  dvd_sel = DVD_W'(power_reg);
                    PAGE_ENERGY: dvd_sel = DVD_W'(energy_reg);
                    PAGE_CHARGE: dvd_sel = DVD_W'(charge_reg);
                    default:     dvd_sel = DVD_W'(seconds_reg);
                endcase
            end
        endcase
        unique case (uw_cur.div_const)
            DC_MS:   dvs_sel = DIV_MS;
            DC_HOUR: dvs_sel = DIV_HOUR;
            default: begin
                unique case (page_w)
                    PAGE_ENERGY: dvs_sel = energy_big ? DIV_BIG : DIV_MS;
                    PAGE_CHARGE: dvs_sel = charge_big ? DIV_BIG : DIV_MS;
                    default:     dvs_sel = DIV_MS;
                endcase
            end
        endcase
    end

    // Four restoring division steps per cycle
    always_comb begin
        div_r = {1'b0, rem_reg};
        div_q = qd_reg;
        for (int k = 0; k < DIV_BPC; k++) begin
            div_r = {div_r[DIV_W-1:0], div_q[DVD_W-1]};
            div_q = {div_q[DVD_W-2:0], 1'b0};
            if (div_r >= {1'b0, divisor_reg}) begin
                div_r    = div_r - {1'b0, divisor_reg};
                div_q[0] = 1'b1;
            end
        end
        rem_next = div_r[DIV_W-1:0];
        qd_next  = div_q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg <= '0;
        end else if (uw_cur.div_load) begin
            div_cnt_reg <= DCNT_W'(DIV_CYCLES);
        end else if (uw_cur.jmp == J_DIV) begin
            div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (uw_cur.div_load) begin
            qd_reg      <= dvd_sel;
            rem_reg     <= '0;
            divisor_reg <= dvs_sel;
        end else if (uw_cur.jmp == J_DIV) begin
            qd_reg  <= qd_next;
            rem_reg <= rem_next;
        end
    end

    // Accumulate totals; clear after this item's accumulation
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dur_reg      <= '0;
            energy_reg   <= '0;
            charge_reg   <= '0;
            setpoint_reg <= SETPOINT_RESET;
        end else begin
            if (uw_cur.misc_upd) begin
                dur_reg      <= dur_reg + ACC_W'(ivl_reg);
                setpoint_reg <= setpoint_next;
            end
            if (uw_cur.wb == WB_CHARGE) charge_reg <= charge_reg + qd_reg[ACC_W-1:0];
            if (uw_cur.wb == WB_ENERGY) begin
                if (clr_reg) begin
                    dur_reg    <= '0;
                    energy_reg <= '0;
                    charge_reg <= '0;
                end else begin
                    energy_reg <= energy_reg + qd_reg[ACC_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (uw_cur.wb == WB_POWER)   power_reg   <= qd_reg[POWER_W-1:0];
        if (uw_cur.wb == WB_SECONDS) seconds_reg <= qd_reg[SEC_W-1:0];
    end

    // Pick value and unit for the page
    always_comb begin
        unique case (page_w)
            PAGE_POWER: begin
                pval_w  = power_big ? qd_reg[POWER_W-1:0] : power_reg;
                punit_w = power_big ? UNIT_W_ : UNIT_MW;
            end
            PAGE_ENERGY: begin
                pval_w  = qd_reg[POWER_W-1:0];
                punit_w = energy_big ? UNIT_WH : UNIT_MWH;
            end
            PAGE_CHARGE: begin
                pval_w  = qd_reg[POWER_W-1:0];
                punit_w = charge_big ? UNIT_AH : UNIT_MAH;
            end
            default: begin
                pval_w  = POWER_W'(seconds_reg);
                punit_w = UNIT_HMS;
            end
        endcase
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (out_fire) begin
            m_power_mw             <= power_reg;
            m_energy_uwh           <= energy_reg;
            m_charge_uah           <= charge_reg;
            m_elapsed_s            <= seconds_reg;
            m_setpoint_mv          <= setpoint_reg;
            m_page                 <= page_w;
            m_page_value           <= pval_w;
            m_page_unit            <= punit_w;
            m_qualified_current_ma <= curr_reg;
        end
    end

    // Checks
    a_one_item_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item taken while the sequencer is busy");

    a_result_from_out_step: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(pc_reg) == UPC_OUT)
        else $error("result raised outside the output step");

    a_div_count_live: assert property (@(posedge aclk) disable iff (!aresetn)
        uw_cur.jmp == J_DIV |-> div_cnt_reg != '0)
        else $error("divide step with no iterations left");

    a_rem_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        uw_cur.jmp == J_DIV |-> rem_reg < divisor_reg)
        else $error("partial remainder not below divisor");

endmodule

`default_nettype wire
